### src/fer_pkg.sv
// Shared types and constants for the FAT entry reader.
`default_nettype none
package fer_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int ADDR_W       = $clog2(SECTOR_BYTES);
  localparam int FILL_W       = $clog2(SECTOR_BYTES + 1);

  localparam logic [1:0] OP_LOOKUP     = 2'd0;
  localparam logic [1:0] OP_BYTE       = 2'd1;
  localparam logic [1:0] OP_FAIL       = 2'd2;
  localparam logic [1:0] OP_INVALIDATE = 2'd3;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  localparam logic OUT_REQUEST = 1'b0;
  localparam logic OUT_ANSWER  = 1'b1;

  localparam logic [2:0] CFG_FAT_KIND     = 3'd0;
  localparam logic [2:0] CFG_FAT_START    = 3'd1;
  localparam logic [2:0] CFG_DATA_START   = 3'd2;
  localparam logic [2:0] CFG_SEC_PER_CLUS = 3'd3;
  localparam logic [2:0] CFG_ENTRY_COUNT  = 3'd4;

  localparam logic [27:0] BAD_FAT12 = 28'h0000FF7;
  localparam logic [27:0] BAD_FAT16 = 28'h000FFF7;
  localparam logic [27:0] BAD_FAT32 = 28'hFFFFFF7;
  localparam logic [27:0] EOC_FAT12 = 28'h0000FF8;
  localparam logic [27:0] EOC_FAT16 = 28'h000FFF8;
  localparam logic [27:0] EOC_FAT32 = 28'hFFFFFF8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_CHECK,
    ST_DECIDE,
    ST_READ,
    ST_FIN,
    ST_ANS
  } state_t;

  typedef enum logic [1:0] {
    MODE_LOOKUP,
    MODE_SPLIT,
    MODE_FAIL
  } mode_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [1:0] lane;
    logic [1:0] kind;
    logic       odd;
  } asm_ctl_t;

endpackage
`default_nettype wire

### src/fer_sector_ram.sv
// Byte-wide sector buffer, one write port and one registered read port.
`default_nettype none
module fer_sector_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/fer_entry_asm.sv
// Gathers entry bytes, one per cycle while ctl.load is set, and decodes the entry value and flags.
`default_nettype none
module fer_entry_asm import fer_pkg::*; (
  input  wire logic     clk,
  input  wire asm_ctl_t ctl,
  input  wire logic [7:0] byte_in,
  output logic [27:0]   value,
  output logic          is_bad,
  output logic          is_eoc
);

  logic [31:0] acc_r;
  logic [7:0]  b0;
  logic [7:0]  b1;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.load) begin
      acc_r[ctl.lane*8 +: 8] <= byte_in;
    end
  end

  assign b0 = acc_r[7:0];
  assign b1 = acc_r[15:8];

  always_comb begin
    value  = '0;
    is_bad = 1'b0;
    is_eoc = 1'b0;
    unique case (ctl.kind)
      KIND_FAT12: begin
        value  = ctl.odd ? {16'd0, b1, b0[7:4]} : {16'd0, b1[3:0], b0};
        is_bad = (value == BAD_FAT12);
        is_eoc = (value >= EOC_FAT12);
      end
      KIND_FAT16: begin
        value  = {12'd0, acc_r[15:0]};
        is_bad = (value == BAD_FAT16);
        is_eoc = (value >= EOC_FAT16);
      end
      KIND_FAT32: begin
        value  = acc_r[27:0];
        is_bad = (value == BAD_FAT32);
        is_eoc = (value >= EOC_FAT32);
      end
      default: begin
        value = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/fat_entry_reader_with_sector_cache.sv
// Top level: FAT12/16/32 entry lookup with a one-sector cache.
//
// Input: start/busy. A word is taken when start is high and busy is low.
// operation selects lookup, sector data byte, read failure or invalidate.
// Output: out_strobe marks each result word for one cycle; the receiver
// cannot stall, so every strobed word must be taken as it appears.
// Config: cfg_valid/cfg_ready (always ready), cfg_index selects the register.
// A lookup hit goes through CHECK for offset/sector/multiply, DECIDE for the
// cache decision, then READ, one byte per cycle from the single read port of
// the sector buffer, then FIN and ANS. A miss emits a read request from
// DECIDE and then takes 512 data bytes, one per cycle with busy low. The last
// byte starts a redo of the lookup (or completion of a split FAT12 entry),
// which then runs through the same states as a hit. A read failure goes
// through CHECK and DECIDE and is answered with an error word.
// Invalidate and ignored words leave busy low and give no result.
// Synchronous reset clears the cache and fill count, resets config registers;
// the sector buffer needs no clearing since only filled sectors are read.
`default_nettype none
module fat_entry_reader_with_sector_cache import fer_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [27:0] in_cluster,
  input  wire logic [7:0]  in_sector_byte,
  output logic             out_strobe,
  output logic             out_kind,
  output logic [31:0]      out_sector_address,
  output logic [27:0]      out_entry_value,
  output logic             out_status,
  output logic             out_is_bad,
  output logic             out_is_end_of_chain,
  output logic [31:0]      out_cluster_first_sector,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   phase2_r, phase2_nxt;
  logic   cache_valid_r, cache_valid_nxt;
  logic [31:0] cached_sec_r, cached_sec_nxt;
  logic [FILL_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic   rd_pend_r, rd_pend_nxt;
  logic   out_strobe_r, out_strobe_nxt;

  logic [1:0]  fat_kind_r;
  logic [31:0] fat_start_r;
  logic [31:0] data_start_r;
  logic [7:0]  spc_r;
  logic [28:0] entry_count_r;

  logic [27:0] pend_c_r, pend_c_nxt;
  logic [31:0] sec_r;
  logic [ADDR_W-1:0] io_r;
  logic        err_r;
  logic [31:0] prod_r;
  logic [1:0]  rd_k_r, rd_k_nxt;
  logic [1:0]  rd_lane_r, rd_lane_nxt;

  logic        o_kind_nxt, o_status_nxt, o_bad_nxt, o_eoc_nxt;
  logic [31:0] o_addr_nxt, o_cfs_nxt;
  logic [27:0] o_val_nxt;

  logic [29:0] off;
  logic [31:0] sec_calc;
  logic [39:0] prod_full;
  logic        split12;
  logic [1:0]  rd_last;
  logic [ADDR_W:0] rd_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic        rd_in_range;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  asm_ctl_t    asm_ctl;
  logic [27:0] asm_value;
  logic        asm_bad, asm_eoc;
  logic        accept;

  assign accept    = start && !busy;
  assign busy      = !(state_r == ST_IDLE || state_r == ST_WAIT);
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_kind_r    <= KIND_FAT12;
      fat_start_r   <= '0;
      data_start_r  <= '0;
      spc_r         <= 8'd1;
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FAT_KIND:     fat_kind_r    <= cfg_data[1:0];
        CFG_FAT_START:    fat_start_r   <= cfg_data;
        CFG_DATA_START:   data_start_r  <= cfg_data;
        CFG_SEC_PER_CLUS: spc_r         <= cfg_data[7:0];
        CFG_ENTRY_COUNT:  entry_count_r <= cfg_data[28:0];
        default: ;
      endcase
    end
  end

  // offset, sector and first data sector arithmetic
  always_comb begin
    unique case (fat_kind_r)
      KIND_FAT12: off = 30'({1'b0, pend_c_r}) + 30'(pend_c_r[27:1]);
      KIND_FAT16: off = {1'b0, pend_c_r, 1'b0};
      default:    off = {pend_c_r, 2'b00};
    endcase
  end

  assign sec_calc  = fat_start_r + 32'(off[29:ADDR_W]);
  assign prod_full = ({4'd0, pend_c_r} - 32'd2) * spc_r;

  assign split12 = (mode_r == MODE_LOOKUP) && (fat_kind_r == KIND_FAT12) &&
                   (io_r == ADDR_W'(SECTOR_BYTES - 1));

  always_comb begin
    if (mode_r == MODE_SPLIT || split12) begin
      rd_last = 2'd0;
    end else if (fat_kind_r == KIND_FAT32) begin
      rd_last = 2'd3;
    end else begin
      rd_last = 2'd1;
    end
  end

  assign rd_sum      = (mode_r == MODE_SPLIT) ? '0 : ({1'b0, io_r} + (ADDR_W+1)'(rd_k_r));
  assign rd_in_range = (rd_sum < (ADDR_W+1)'(SECTOR_BYTES));
  assign rd_addr     = rd_sum[ADDR_W-1:0];

  fer_sector_ram #(
    .DEPTH(SECTOR_BYTES),
    .WIDTH(8)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_cnt_r[ADDR_W-1:0]),
    .wdata(in_sector_byte),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    asm_ctl.clear = (state_r == ST_CHECK) && (mode_r == MODE_LOOKUP);
    asm_ctl.load  = rd_pend_r;
    asm_ctl.lane  = rd_lane_r;
    asm_ctl.kind  = (mode_r == MODE_SPLIT) ? KIND_FAT12 : fat_kind_r;
    asm_ctl.odd   = pend_c_r[0];
  end

  fer_entry_asm u_asm (
    .clk    (clk),
    .ctl    (asm_ctl),
    .byte_in(ram_rdata),
    .value  (asm_value),
    .is_bad (asm_bad),
    .is_eoc (asm_eoc)
  );

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    phase2_nxt      = phase2_r;
    cache_valid_nxt = cache_valid_r;
    cached_sec_nxt  = cached_sec_r;
    fill_cnt_nxt    = fill_cnt_r;
    rd_pend_nxt     = 1'b0;
    rd_k_nxt        = rd_k_r;
    rd_lane_nxt     = rd_lane_r;
    pend_c_nxt      = pend_c_r;
    out_strobe_nxt  = 1'b0;
    ram_we          = 1'b0;
    o_kind_nxt      = out_kind;
    o_addr_nxt      = out_sector_address;
    o_val_nxt       = out_entry_value;
    o_status_nxt    = out_status;
    o_bad_nxt       = out_is_bad;
    o_eoc_nxt       = out_is_end_of_chain;
    o_cfs_nxt       = out_cluster_first_sector;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_LOOKUP: begin
              pend_c_nxt = in_cluster;
              mode_nxt   = MODE_LOOKUP;
              state_nxt  = ST_CHECK;
            end
            OP_INVALIDATE: cache_valid_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      ST_WAIT: begin
        if (accept) begin
          unique case (in_operation)
            OP_BYTE: begin
              ram_we = 1'b1;
              if (fill_cnt_r == FILL_W'(SECTOR_BYTES - 1)) begin
                fill_cnt_nxt    = '0;
                cache_valid_nxt = 1'b1;
                mode_nxt        = phase2_r ? MODE_SPLIT : MODE_LOOKUP;
                phase2_nxt      = 1'b0;
                state_nxt       = ST_CHECK;
              end else begin
                fill_cnt_nxt = fill_cnt_r + 1'b1;
              end
            end
            OP_FAIL: begin
              cache_valid_nxt = 1'b0;
              fill_cnt_nxt    = '0;
              phase2_nxt      = 1'b0;
              mode_nxt        = MODE_FAIL;
              state_nxt       = ST_CHECK;
            end
            OP_INVALIDATE: cache_valid_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        rd_k_nxt  = '0;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (mode_r == MODE_FAIL || (mode_r == MODE_LOOKUP && err_r)) begin
          out_strobe_nxt = 1'b1;
          o_kind_nxt     = OUT_ANSWER;
          o_addr_nxt     = '0;
          o_val_nxt      = '0;
          o_status_nxt   = 1'b1;
          o_bad_nxt      = 1'b0;
          o_eoc_nxt      = 1'b0;
          o_cfs_nxt      = data_start_r + prod_r;
          state_nxt      = ST_IDLE;
        end else if (mode_r == MODE_LOOKUP &&
                     !(cache_valid_r && cached_sec_r == sec_r)) begin
          cache_valid_nxt = 1'b0;
          cached_sec_nxt  = sec_r;
          fill_cnt_nxt    = '0;
          phase2_nxt      = 1'b0;
          out_strobe_nxt  = 1'b1;
          o_kind_nxt      = OUT_REQUEST;
          o_addr_nxt      = sec_r;
          o_val_nxt       = '0;
          o_status_nxt    = 1'b0;
          o_bad_nxt       = 1'b0;
          o_eoc_nxt       = 1'b0;
          o_cfs_nxt       = '0;
          state_nxt       = ST_WAIT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_pend_nxt = rd_in_range;
        rd_lane_nxt = (mode_r == MODE_SPLIT) ? 2'd1 : rd_k_r;
        if (rd_k_r == rd_last) begin
          state_nxt = ST_FIN;
        end else begin
          rd_k_nxt = rd_k_r + 1'b1;
        end
      end
      ST_FIN: begin
        state_nxt = ST_ANS;
      end
      ST_ANS: begin
        out_strobe_nxt = 1'b1;
        if (split12) begin
          cache_valid_nxt = 1'b0;
          cached_sec_nxt  = sec_r + 32'd1;
          fill_cnt_nxt    = '0;
          phase2_nxt      = 1'b1;
          o_kind_nxt      = OUT_REQUEST;
          o_addr_nxt      = sec_r + 32'd1;
          o_val_nxt       = '0;
          o_status_nxt    = 1'b0;
          o_bad_nxt       = 1'b0;
          o_eoc_nxt       = 1'b0;
          o_cfs_nxt       = '0;
          state_nxt       = ST_WAIT;
        end else begin
          o_kind_nxt   = OUT_ANSWER;
          o_addr_nxt   = '0;
          o_val_nxt    = asm_value;
          o_status_nxt = 1'b0;
          o_bad_nxt    = asm_bad;
          o_eoc_nxt    = asm_eoc;
          o_cfs_nxt    = data_start_r + prod_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_LOOKUP;
      phase2_r      <= 1'b0;
      cache_valid_r <= 1'b0;
      cached_sec_r  <= '0;
      fill_cnt_r    <= '0;
      rd_pend_r     <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      phase2_r      <= phase2_nxt;
      cache_valid_r <= cache_valid_nxt;
      cached_sec_r  <= cached_sec_nxt;
      fill_cnt_r    <= fill_cnt_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_c_r  <= pend_c_nxt;
    rd_k_r    <= rd_k_nxt;
    rd_lane_r <= rd_lane_nxt;
    if (state_r == ST_CHECK) begin
      sec_r  <= sec_calc;
      io_r   <= off[ADDR_W-1:0];
      err_r  <= ({1'b0, pend_c_r} >= entry_count_r) || (fat_kind_r == 2'd3);
      prod_r <= prod_full[31:0];
    end
    out_kind                 <= o_kind_nxt;
    out_sector_address       <= o_addr_nxt;
    out_entry_value          <= o_val_nxt;
    out_status               <= o_status_nxt;
    out_is_bad               <= o_bad_nxt;
    out_is_end_of_chain      <= o_eoc_nxt;
    out_cluster_first_sector <= o_cfs_nxt;
  end

  assign out_strobe = out_strobe_r;

`ifndef SYNTH
  a_req_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == OUT_REQUEST |-> state_r == ST_WAIT && !cache_valid_r)
    else $error("read request without entering wait");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r < FILL_W'(SECTOR_BYTES))
    else $error("fill count out of range");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result words back to back");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status |-> out_entry_value == '0 && !out_is_bad && !out_is_end_of_chain)
    else $error("error answer carries entry data");
`endif

endmodule
`default_nettype wire

### tb/fer_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Entry lookup predictor and result scoreboard for the FAT entry reader testbench.
package fer_scoreboard_pkg;
  import fer_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] sector_address;
    logic [27:0] entry_value;
    logic        status;
    logic        is_bad;
    logic        is_end_of_chain;
    logic [31:0] cluster_first_sector;
  } fat_answer_t;

  typedef enum int {
    WAIT_NONE,
    WAIT_ENTRY_SECTOR,
    WAIT_SPLIT_SECTOR
  } wait_phase_e;

  class fat_lookup_scoreboard;
    logic [1:0]  fat_kind;
    logic [31:0] fat_start;
    logic [31:0] data_start;
    logic [7:0]  clus_sectors;
    logic [28:0] entry_count;
    bit          cache_valid;
    logic [31:0] cached_sector;
    logic [7:0]  sector_copy [SECTOR_BYTES];
    logic [27:0] pending_cluster;
    wait_phase_e wait_phase;
    int          fill_count;
    logic [7:0]  saved_low_byte;
    fat_answer_t expected_answers [$];
    int          answers_checked;
    int          errors;

    function new();
      fat_kind        = KIND_FAT12;
      fat_start       = '0;
      data_start      = '0;
      clus_sectors    = 8'd1;
      entry_count     = '0;
      cache_valid     = 1'b0;
      cached_sector   = '0;
      pending_cluster = '0;
      wait_phase      = WAIT_NONE;
      fill_count      = 0;
      saved_low_byte  = '0;
      answers_checked = 0;
      errors          = 0;
      foreach (sector_copy[i]) sector_copy[i] = 8'h00;
    endfunction

    function void write_register(logic [2:0] index, logic [31:0] data);
      case (index)
        CFG_FAT_KIND:     fat_kind = data[1:0];
        CFG_FAT_START:    fat_start = data;
        CFG_DATA_START:   data_start = data;
        CFG_SEC_PER_CLUS: clus_sectors = data[7:0];
        CFG_ENTRY_COUNT:  entry_count = data[28:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] first_sector(logic [27:0] c);
      logic [31:0] rel;
      rel = {4'd0, c} - 32'd2;
      return data_start + rel * {24'd0, clus_sectors};
    endfunction

    function logic [27:0] fat12_entry(logic [27:0] c, logic [7:0] lo, logic [7:0] hi);
      if (c[0]) return {16'd0, hi, lo[7:4]};
      return {16'd0, hi[3:0], lo};
    endfunction

    function void push_answer(logic [1:0] kind, logic [27:0] v, logic [27:0] c);
      logic [27:0] bad_mark;
      logic [27:0] eoc_mark;
      fat_answer_t a;
      case (kind)
        KIND_FAT12: begin
          bad_mark = BAD_FAT12;
          eoc_mark = EOC_FAT12;
        end
        KIND_FAT16: begin
          bad_mark = BAD_FAT16;
          eoc_mark = EOC_FAT16;
        end
        default: begin
          bad_mark = BAD_FAT32;
          eoc_mark = EOC_FAT32;
        end
      endcase
      a = '0;
      a.kind = OUT_ANSWER;
      a.entry_value = v;
      a.is_bad = (v == bad_mark);
      a.is_end_of_chain = (v >= eoc_mark);
      a.cluster_first_sector = first_sector(c);
      expected_answers.push_back(a);
    endfunction

    function void push_error(logic [27:0] c);
      fat_answer_t a;
      a = '0;
      a.kind = OUT_ANSWER;
      a.status = 1'b1;
      a.cluster_first_sector = first_sector(c);
      expected_answers.push_back(a);
    endfunction

    function void push_request(logic [31:0] sector, logic [27:0] c, wait_phase_e phase);
      fat_answer_t a;
      cache_valid     = 1'b0;
      cached_sector   = sector;
      pending_cluster = c;
      wait_phase      = phase;
      fill_count      = 0;
      a = '0;
      a.kind = OUT_REQUEST;
      a.sector_address = sector;
      expected_answers.push_back(a);
    endfunction

    function void lookup(logic [27:0] c);
      logic [31:0] offset;
      logic [31:0] sector;
      logic [27:0] v;
      int          idx;
      if ({1'b0, c} >= entry_count || fat_kind > KIND_FAT32) begin
        push_error(c);
        return;
      end
      case (fat_kind)
        KIND_FAT12: offset = {4'd0, c} + {5'd0, c[27:1]};
        KIND_FAT16: offset = {3'd0, c, 1'b0};
        default:    offset = {2'd0, c, 2'b00};
      endcase
      sector = fat_start + offset / SECTOR_BYTES;
      idx = int'(offset % SECTOR_BYTES);
      if (!(cache_valid && cached_sector == sector)) begin
        push_request(sector, c, WAIT_ENTRY_SECTOR);
        return;
      end
      case (fat_kind)
        KIND_FAT12: begin
          // entry straddles two sectors: keep the low byte, fetch the next one
          if (idx == SECTOR_BYTES - 1) begin
            saved_low_byte = sector_copy[idx];
            push_request(sector + 32'd1, c, WAIT_SPLIT_SECTOR);
            return;
          end
          v = fat12_entry(c, sector_copy[idx], sector_copy[idx + 1]);
        end
        KIND_FAT16: v = {12'd0, sector_copy[idx + 1], sector_copy[idx]};
        default: v = {sector_copy[idx + 3][3:0], sector_copy[idx + 2],
                      sector_copy[idx + 1], sector_copy[idx]};
      endcase
      push_answer(fat_kind, v, c);
      wait_phase = WAIT_NONE;
    endfunction

    function void predict_word(logic [1:0] op, logic [27:0] c, logic [7:0] data);
      case (op)
        OP_LOOKUP: begin
          if (wait_phase == WAIT_NONE) lookup(c);
        end
        OP_INVALIDATE: cache_valid = 1'b0;
        default: begin
          if (wait_phase != WAIT_NONE) begin
            if (op == OP_FAIL) begin
              cache_valid = 1'b0;
              wait_phase  = WAIT_NONE;
              fill_count  = 0;
              push_error(pending_cluster);
            end else begin
              sector_copy[fill_count] = data;
              fill_count++;
              if (fill_count == SECTOR_BYTES) begin
                fill_count  = 0;
                cache_valid = 1'b1;
                if (wait_phase == WAIT_SPLIT_SECTOR) begin
                  wait_phase = WAIT_NONE;
                  push_answer(KIND_FAT12,
                              fat12_entry(pending_cluster, saved_low_byte, sector_copy[0]),
                              pending_cluster);
                end else begin
                  wait_phase = WAIT_NONE;
                  lookup(pending_cluster);
                end
              end
            end
          end
        end
      endcase
    endfunction

    function string describe(fat_answer_t a);
      return $sformatf("kind %0d addr %h value %h status %0d bad %0d eoc %0d first %h",
                       a.kind, a.sector_address, a.entry_value, a.status, a.is_bad,
                       a.is_end_of_chain, a.cluster_first_sector);
    endfunction

    function void check_result(fat_answer_t got);
      fat_answer_t want;
      if (expected_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("stray result word: %s", describe(got));
        return;
      end
      want = expected_answers.pop_front();
      answers_checked++;
      if (got.kind !== want.kind || got.sector_address !== want.sector_address ||
          got.entry_value !== want.entry_value || got.status !== want.status ||
          got.is_bad !== want.is_bad || got.is_end_of_chain !== want.is_end_of_chain ||
          got.cluster_first_sector !== want.cluster_first_sector) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch, expected %s", describe(want));
          $display("                 actual   %s", describe(got));
        end
      end
    endfunction
  endclass

endpackage

### tb/fat_entry_reader_with_sector_cache_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives lookups, sector fills and register writes, checks every result word.
module fat_entry_reader_with_sector_cache_tb;
  import fer_pkg::*;
  import fer_scoreboard_pkg::*;

  localparam int RANDOM_WORDS  = 950;
  localparam int LAYOUT_COUNT  = 8;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum int {
    FILL_CLEAN,
    FILL_FAIL_NOW,
    FILL_FAIL_LATE,
    FILL_NOISY
  } fill_mode_e;

  typedef enum int {
    BYTES_RANDOM,
    BYTES_MARKERS,
    BYTES_BAD_PATTERN,
    BYTES_ONES,
    BYTES_ZEROS
  } byte_style_e;

  typedef struct {
    logic [1:0]  fat_kind;
    logic [31:0] fat_start;
    logic [31:0] data_start;
    logic [7:0]  clus_sectors;
    logic [28:0] entry_count;
  } fat_layout_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = OP_LOOKUP;
  logic [27:0] in_cluster = '0;
  logic [7:0]  in_sector_byte = '0;
  logic        out_strobe;
  logic        out_kind;
  logic [31:0] out_sector_address;
  logic [27:0] out_entry_value;
  logic        out_status;
  logic        out_is_bad;
  logic        out_is_end_of_chain;
  logic [31:0] out_cluster_first_sector;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_FAT_KIND;
  logic [31:0] cfg_data = '0;

  fat_lookup_scoreboard answer_book;
  int          idle_pct = 0;
  int          words_sent = 0;
  int          fills_done = 0;
  int unsigned cycle_count = 0;

  fat_entry_reader_with_sector_cache u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_operation             (in_operation),
    .in_cluster               (in_cluster),
    .in_sector_byte           (in_sector_byte),
    .out_strobe               (out_strobe),
    .out_kind                 (out_kind),
    .out_sector_address       (out_sector_address),
    .out_entry_value          (out_entry_value),
    .out_status               (out_status),
    .out_is_bad               (out_is_bad),
    .out_is_end_of_chain      (out_is_end_of_chain),
    .out_cluster_first_sector (out_cluster_first_sector),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fat_entry_reader_with_sector_cache_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      answer_book.check_result({out_kind, out_sector_address, out_entry_value, out_status,
                                out_is_bad, out_is_end_of_chain, out_cluster_first_sector});
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [27:0] cl, input logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_cluster     <= cl;
    in_sector_byte <= data;
    do @(posedge clk); while (busy);
    answer_book.predict_word(op, cl, data);
    words_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (answer_book.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    answer_book.write_register(index, data);
  endtask

  task automatic apply_layout(input fat_layout_t lay);
    wait_idle();
    write_register(CFG_FAT_KIND, {30'd0, lay.fat_kind});
    write_register(CFG_FAT_START, lay.fat_start);
    write_register(CFG_DATA_START, lay.data_start);
    write_register(CFG_SEC_PER_CLUS, {24'd0, lay.clus_sectors});
    write_register(CFG_ENTRY_COUNT, {3'd0, lay.entry_count});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] fill_byte(byte_style_e style, int n);
    case (style)
      BYTES_MARKERS: begin
        case ($urandom_range(6))
          0: return 8'h00;
          1: return 8'hFF;
          2: return 8'hF7;
          3: return 8'hF8;
          4: return 8'h0F;
          5: return 8'h7F;
          default: return 8'($urandom);
        endcase
      end
      BYTES_BAD_PATTERN: begin
        case (n % 4)
          0: return 8'hF7;
          3: return 8'h0F;
          default: return 8'hFF;
        endcase
      end
      BYTES_ONES:  return 8'hFF;
      BYTES_ZEROS: return 8'h00;
      default:     return 8'($urandom);
    endcase
  endfunction

  task automatic serve_fill(input fill_mode_e mode);
    int          fail_at;
    byte_style_e style;
    style = byte_style_e'($urandom_range(4));
    case (mode)
      FILL_FAIL_NOW:  fail_at = 0;
      FILL_FAIL_LATE: fail_at = $urandom_range(1, SECTOR_BYTES - 1);
      default:        fail_at = SECTOR_BYTES;
    endcase
    for (int n = 0; n < SECTOR_BYTES; n++) begin
      if (n == fail_at) begin
        send_word(OP_FAIL, 28'($urandom), 8'($urandom));
        return;
      end
      // lookups are ignored mid-fill; invalidate must not stop the fill
      if (mode == FILL_NOISY && $urandom_range(99) < 3) begin
        send_word(($urandom_range(1) != 0) ? OP_LOOKUP : OP_INVALIDATE,
                  28'($urandom), 8'($urandom));
      end
      send_word(OP_BYTE, 28'($urandom), fill_byte(style, n));
    end
    fills_done++;
  endtask

  task automatic lookup_txn(input logic [27:0] cl, input fill_mode_e mode);
    send_word(OP_LOOKUP, cl, 8'($urandom));
    while (answer_book.wait_phase != WAIT_NONE) serve_fill(mode);
  endtask

  initial begin
    fat_layout_t layouts [LAYOUT_COUNT];
    longint      span;
    longint      hot;
    longint      pick;
    int          counted;
    int          phase_words;
    int          r;
    fill_mode_e  mode;

    answer_book = new();
    layouts[0] = '{KIND_FAT12, 32'd0, 32'd100, 8'd1, 29'd4096};
    layouts[1] = '{KIND_FAT16, 32'hFFFF_FFF0, 32'hFFFF_FF00, 8'd128, 29'd65536};
    layouts[2] = '{KIND_FAT32, 32'h0000_0020, 32'd0, 8'd255, 29'h1FFF_FFFF};
    layouts[3] = '{KIND_FAT12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 29'h1000_0000};
    layouts[4] = '{KIND_UNUSED, $urandom, $urandom, 8'($urandom), 29'($urandom)};
    layouts[5] = '{KIND_FAT32, $urandom, $urandom, 8'($urandom_range(1, 128)),
                   29'($urandom_range(1000, 28'hFFF_FFFF))};
    layouts[6] = '{KIND_FAT16, $urandom, $urandom, 8'($urandom_range(1, 128)), 29'd300};
    layouts[7] = '{KIND_FAT12, $urandom, $urandom, 8'($urandom_range(1, 128)),
                   29'($urandom_range(2, 4096))};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: every lookup is out of range
    idle_pct = 22;
    lookup_txn(28'd0, FILL_CLEAN);
    lookup_txn(28'hFFF_FFFF, FILL_CLEAN);
    send_word(OP_BYTE, 28'd0, 8'hA5);
    send_word(OP_FAIL, 28'd0, 8'h5A);
    send_word(OP_INVALIDATE, 28'd0, 8'h00);

    apply_layout(layouts[0]);
    lookup_txn(28'd0, FILL_CLEAN);
    lookup_txn(28'd1, FILL_CLEAN);
    lookup_txn(28'd2, FILL_CLEAN);
    lookup_txn(28'd341, FILL_CLEAN);
    lookup_txn(28'd682, FILL_CLEAN);
    lookup_txn(28'd4095, FILL_CLEAN);
    lookup_txn(28'd4096, FILL_CLEAN);
    lookup_txn(28'd2000, FILL_FAIL_NOW);
    lookup_txn(28'd2001, FILL_FAIL_LATE);
    lookup_txn(28'd3000, FILL_NOISY);
    send_word(OP_INVALIDATE, 28'($urandom), 8'($urandom));
    lookup_txn(28'd3001, FILL_CLEAN);
    lookup_txn(28'd3002, FILL_CLEAN);

    counted = 0;
    for (int p = 0; p < LAYOUT_COUNT; p++) begin
      apply_layout(layouts[p]);
      span = longint'(layouts[p].entry_count) + 16;
      if (span > 28'hFFF_FFFF) span = 28'hFFF_FFFF;
      hot = longint'($urandom_range(0, int'(span)));
      phase_words = 0;
      while (phase_words < RANDOM_WORDS / LAYOUT_COUNT) begin
        if (counted < RANDOM_WORDS / 3) idle_pct = 22;
        else if (counted < 2 * RANDOM_WORDS / 3) idle_pct = 68;
        else idle_pct = 0;
        if (counted == RANDOM_WORDS / 2) wait_idle();
        r = $urandom_range(99);
        if (r < 6) begin
          send_word(OP_INVALIDATE, 28'($urandom), 8'($urandom));
        end else if (r < 12) begin
          // stray data or failure with no read pending: ignored, not counted
          send_word(($urandom_range(1) != 0) ? OP_BYTE : OP_FAIL, 28'($urandom),
                    8'($urandom));
          continue;
        end else begin
          if (r < 62) pick = hot + longint'($urandom_range(40)) - 20;
          else if (r < 72) pick = longint'($urandom_range(0, int'(span)));
          else if (r < 80) pick = (($urandom_range(1) != 0) ? 341 : 682) +
                                  1024 * longint'($urandom_range(0, int'(span / 1024)));
          else if (r < 88) pick = longint'(layouts[p].entry_count) - 1 +
                                  longint'($urandom_range(2));
          else pick = longint'($urandom_range(0, 28'hFFF_FFFF));
          if (pick < 0) pick = 0;
          if (pick > 28'hFFF_FFFF) pick = 28'hFFF_FFFF;
          hot = pick;
          r = $urandom_range(99);
          if (r < 72) mode = FILL_CLEAN;
          else if (r < 80) mode = FILL_FAIL_NOW;
          else if (r < 88) mode = FILL_FAIL_LATE;
          else mode = FILL_NOISY;
          lookup_txn(28'(pick), mode);
        end
        counted++;
        phase_words++;
      end
    end

    wait_idle();
    $display("Drove %0d accepted words under %0d register layouts, %0d complete sector fills.",
             words_sent, LAYOUT_COUNT + 1, fills_done);
    $display("Compared %0d result words; %0d wrong or unexpected.",
             answer_book.answers_checked, answer_book.errors);
    if (answer_book.errors == 0 && answer_book.expected_answers.size() == 0) begin
      $display("fat_entry_reader_with_sector_cache_tb: clean");
    end else begin
      $display("fat_entry_reader_with_sector_cache_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/fer_pkg.sv
src/fer_sector_ram.sv
src/fer_entry_asm.sv
src/fat_entry_reader_with_sector_cache.sv
tb/fer_scoreboard_pkg.sv
tb/fat_entry_reader_with_sector_cache_tb.sv
